[rtl/core/irta_pkg.sv]
package irta_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [CNT_W-1:0] SLOT_END  = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(ENTRIES - 1);

    // Operation codes.
    localparam logic [1:0] FN_FIND   = 2'd0;
    localparam logic [1:0] FN_CHECK  = 2'd1;
    localparam logic [1:0] FN_ADD    = 2'd2;
    localparam logic [1:0] FN_REMOVE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] owner_id;
        logic [31:0] first_id;
        logic [31:0] id_count;
        logic [31:0] limit_low;
        logic [31:0] limit_high;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] free_start;
        logic        covered;
    } out_item_t;

    // One table entry as stored in memory.
    typedef struct packed {
        logic        used;
        logic [31:0] owner;
        logic [31:0] first;
        logic [31:0] count;
    } slot_t;

    // Per-entry compare results handed from the evaluator to the sequencer.
    typedef struct packed {
        logic        used;
        logic        find_hit;
        logic        cont_hit;
        logic        rm_hit;
        logic        rm_lo;
        logic        rm_hi;
        logic [32:0] last;
        logic [32:0] last_p1;
        logic [31:0] head_count;
        logic [31:0] tail_first;
        logic [31:0] tail_count;
    } slot_eval_t;

endpackage

[rtl/core/irta_ram.sv]
module irta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/irta_eval.sv]
module irta_eval
    import irta_pkg::*;
(
    input  slot_t      slot_i,
    input  in_item_t   op_i,
    input  logic [32:0] cand_i,
    input  logic [33:0] cand_end_i,
    output slot_eval_t ev_o
);

    logic [32:0] first_w;
    logic [32:0] last_w;
    logic [32:0] span_start;
    logic [32:0] span_end;
    logic        owner_eq;

    // Range ends are kept at 33 bits so the top id never wraps.
    assign first_w    = {1'b0, slot_i.first};
    assign last_w     = first_w + {1'b0, slot_i.count} - 33'd1;
    assign span_start = {1'b0, op_i.first_id};
    assign span_end   = span_start + {1'b0, op_i.id_count} - 33'd1;
    assign owner_eq   = slot_i.used && (slot_i.owner == op_i.owner_id);

    always_comb begin
        ev_o.used       = slot_i.used;
        ev_o.find_hit   = slot_i.used && ({1'b0, first_w} <= cand_end_i) && (last_w >= cand_i);
        ev_o.cont_hit   = owner_eq && (first_w <= cand_i) && (last_w >= cand_i);
        ev_o.rm_hit     = owner_eq && !((span_end < first_w) || (span_start > last_w));
        ev_o.rm_lo      = span_start <= first_w;
        ev_o.rm_hi      = span_end >= last_w;
        ev_o.last       = last_w;
        ev_o.last_p1    = first_w + {1'b0, slot_i.count};
        ev_o.head_count = 32'(span_start - first_w);
        ev_o.tail_first = 32'(span_end + 33'd1);
        ev_o.tail_count = 32'(last_w - span_end);
    end

endmodule

[rtl/core/id_range_table_allocator_unit.sv]
// Channel  | Direction | Handshake        | Item
// s_       | in        | s_valid/s_ready  | s_data (in_item_t)
// m_       | out       | m_valid/m_ready  | m_data (out_item_t)
//
// The table lives in one memory read one entry per cycle, a pass at a time.
// Remove takes two passes plus an S_SPLIT write and a pass per split; find free, check and add
// repeat a pass each time the candidate moves.
// After reset a clearing pass writes every entry before the first item is taken.
// One item is worked at a time; a finished result waits in the output register,
// and the next item is accepted once the result has been loaded there.
module id_range_table_allocator_unit
    import irta_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SPLIT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    in_item_t         op_reg, op_next;
    logic [32:0]      cand_reg, cand_next;
    logic [33:0]      cand_end_reg, cand_end_next;
    logic             hit_reg, hit_next;
    logic [32:0]      best_reg, best_next;
    logic             free_ok_reg, free_ok_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pr_idx_reg, pr_idx_next;
    logic             phase_free_reg, phase_free_next;
    logic [CNT_W-1:0] resume_reg, resume_next;
    logic [31:0]      tail_first_reg, tail_first_next;
    logic [31:0]      tail_count_reg, tail_count_next;
    out_item_t        res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    slot_t            ram_rdata;
    slot_eval_t       ev;
    logic             pass_end;
    logic             covered_w;

    irta_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    irta_eval u_eval (
        .slot_i    (ram_rdata),
        .op_i      (op_reg),
        .cand_i    (cand_reg),
        .cand_end_i(cand_end_reg),
        .ev_o      (ev)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign ram_re    = (state_reg == S_SCAN) && (rd_idx_reg != SLOT_END);
    assign ram_raddr = rd_idx_reg[IDX_W-1:0];
    assign pass_end  = (state_reg == S_SCAN) && !pend_reg && (rd_idx_reg == SLOT_END);
    assign covered_w = hit_reg && (best_reg >= cand_end_reg[32:0]);

    // Sequencer: starts passes, folds each entry read into the accumulators,
    // and writes new, modified and cleared entries to the memory.
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        cand_next       = cand_reg;
        cand_end_next   = cand_end_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        free_ok_next    = free_ok_reg;
        free_idx_next   = free_idx_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = 1'b0;
        pr_idx_next     = pr_idx_reg;
        phase_free_next = phase_free_reg;
        resume_next     = resume_reg;
        tail_first_next = tail_first_reg;
        tail_count_next = tail_count_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = pr_idx_reg;
        ram_wdata       = ram_rdata;

        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg[IDX_W-1:0];
                ram_wdata = '0;
                rd_idx_next = rd_idx_reg + CNT_W'(1);
                if (rd_idx_reg == SLOT_LAST) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_data;
                    res_next      = '0;
                    rd_idx_next   = '0;
                    hit_next      = 1'b0;
                    best_next     = '0;
                    free_ok_next  = 1'b0;
                    state_next    = S_SCAN;
                    cand_next     = {1'b0, s_data.first_id};
                    cand_end_next = {2'b0, s_data.first_id} + {2'b0, s_data.id_count} - 34'd1;
                    unique case (s_data.func)
                        FN_FIND: begin
                            cand_next     = {1'b0, s_data.limit_low};
                            cand_end_next = {2'b0, s_data.limit_low}
                                          + {2'b0, s_data.id_count} - 34'd1;
                            if ((s_data.id_count == 32'd0)
                                    || (s_data.limit_high < s_data.limit_low)) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_OUT;
                            end
                        end
                        FN_CHECK: begin
                            if (s_data.id_count == 32'd0) begin
                                state_next = S_OUT;
                            end
                        end
                        FN_ADD: begin
                            if (s_data.id_count == 32'd0) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_OUT;
                            end
                        end
                        FN_REMOVE: begin
                            phase_free_next = 1'b1;
                            resume_next     = '0;
                            if (s_data.id_count == 32'd0) begin
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue the next read while the previous entry is evaluated.
                if (ram_re) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                    pr_idx_next = rd_idx_reg[IDX_W-1:0];
                end

                // Fold in the entry that the memory returns this cycle.
                if (pend_reg) begin
                    if (!ev.used && !free_ok_reg) begin
                        free_ok_next  = 1'b1;
                        free_idx_next = pr_idx_reg;
                    end
                    unique case (op_reg.func)
                        FN_FIND: begin
                            if (ev.find_hit) begin
                                hit_next = 1'b1;
                                if (ev.last_p1 > best_reg) begin
                                    best_next = ev.last_p1;
                                end
                            end
                        end
                        FN_CHECK, FN_ADD: begin
                            if (ev.cont_hit) begin
                                hit_next = 1'b1;
                                if (ev.last > best_reg) begin
                                    best_next = ev.last;
                                end
                            end
                        end
                        FN_REMOVE: begin
                            if (!phase_free_reg && ev.rm_hit) begin
                                priority if (ev.rm_lo && ev.rm_hi) begin
                                    ram_we         = 1'b1;
                                    ram_wdata.used = 1'b0;
                                    if (!free_ok_reg || (pr_idx_reg < free_idx_reg)) begin
                                        free_ok_next  = 1'b1;
                                        free_idx_next = pr_idx_reg;
                                    end
                                end else if (ev.rm_lo) begin
                                    ram_we          = 1'b1;
                                    ram_wdata.first = ev.tail_first;
                                    ram_wdata.count = ev.tail_count;
                                end else if (ev.rm_hi) begin
                                    ram_we          = 1'b1;
                                    ram_wdata.count = ev.head_count;
                                end else if (!free_ok_reg) begin
                                    // A split with no spare slot ends the remove.
                                    res_next.status = ST_FULL;
                                    pend_next       = 1'b0;
                                    state_next      = S_OUT;
                                end else begin
                                    ram_we          = 1'b1;
                                    ram_wdata.count = ev.head_count;
                                    tail_first_next = ev.tail_first;
                                    tail_count_next = ev.tail_count;
                                    resume_next     = {1'b0, pr_idx_reg} + CNT_W'(1);
                                    pend_next       = 1'b0;
                                    state_next      = S_SPLIT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                // End of a pass over the table.
                if (pass_end) begin
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    best_next   = '0;
                    unique case (op_reg.func)
                        FN_FIND: begin
                            priority if (cand_end_reg > {2'b0, op_reg.limit_high}) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_OUT;
                            end else if (!hit_reg) begin
                                res_next.free_start = cand_reg[31:0];
                                state_next          = S_OUT;
                            end else begin
                                cand_next     = best_reg;
                                cand_end_next = {1'b0, best_reg}
                                              + {2'b0, op_reg.id_count} - 34'd1;
                            end
                        end
                        FN_CHECK, FN_ADD: begin
                            free_ok_next = 1'b0;
                            if (!hit_reg || covered_w) begin
                                state_next = S_OUT;
                                if (op_reg.func == FN_CHECK) begin
                                    res_next.covered = covered_w;
                                end else if (covered_w) begin
                                    res_next.status = ST_PRESENT;
                                end else if (free_ok_reg) begin
                                    ram_we          = 1'b1;
                                    ram_waddr       = free_idx_reg;
                                    ram_wdata.used  = 1'b1;
                                    ram_wdata.owner = op_reg.owner_id;
                                    ram_wdata.first = op_reg.first_id;
                                    ram_wdata.count = op_reg.id_count;
                                end else begin
                                    res_next.status = ST_FULL;
                                end
                            end else begin
                                cand_next = best_reg + 33'd1;
                            end
                        end
                        FN_REMOVE: begin
                            if (phase_free_reg) begin
                                phase_free_next = 1'b0;
                                rd_idx_next     = resume_reg;
                            end else begin
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SPLIT: begin
                // Store the upper part of the split range, then rescan for a free slot.
                ram_we          = 1'b1;
                ram_waddr       = free_idx_reg;
                ram_wdata.used  = 1'b1;
                ram_wdata.owner = op_reg.owner_id;
                ram_wdata.first = tail_first_reg;
                ram_wdata.count = tail_count_reg;
                free_ok_next    = 1'b0;
                phase_free_next = 1'b1;
                rd_idx_next     = '0;
                state_next      = S_SCAN;
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        cand_reg       <= cand_next;
        cand_end_reg   <= cand_end_next;
        hit_reg        <= hit_next;
        best_reg       <= best_next;
        free_ok_reg    <= free_ok_next;
        free_idx_reg   <= free_idx_next;
        pr_idx_reg     <= pr_idx_next;
        phase_free_reg <= phase_free_next;
        resume_reg     <= resume_next;
        tail_first_reg <= tail_first_next;
        tail_count_reg <= tail_count_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

endmodule
